[design/assert_macros.svh]
// Assertion macros for the checker file of the frame header search core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fhs_pkg.sv]
// Types and fixed constants of the frame header search core.
// No dependencies; imported by every module of the block.
package fhs_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 8;
    localparam int LEN_W     = 4;
    localparam int PAT_W     = 64;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_PATTERN_BYTES  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] start;
    } match_t;

endpackage

[design/fhs_match.sv]
// Parallel window compare: decides whether the header ends at the current byte.
// Depends on fhs_pkg.
module fhs_match #(
    parameter int PATTERN_MAX = 8
) (
    input  logic [PATTERN_MAX*8-1:0]   hist,
    input  logic [fhs_pkg::POS_W-1:0]  seen,
    input  logic [fhs_pkg::LEN_W-1:0]  pattern_length,
    input  logic [fhs_pkg::PAT_W-1:0]  pattern_bytes,
    output fhs_pkg::match_t            match
);
    import fhs_pkg::*;

    logic [PATTERN_MAX-1:0] eq;
    logic [LEN_W-1:0]       len_eff;
    logic [POS_W:0]         count;
    logic                   eq_sel;

    always_comb
    begin
        logic ok;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            ok = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (hist[8*(l-1-i) +: 8] != pattern_bytes[8*i +: 8])
                begin
                    ok = 1'b0;
                end
            end
            eq[l-1] = ok;
        end
    end

    always_comb
    begin
        if (pattern_length > LEN_W'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = pattern_length;
        end
    end

    always_comb
    begin
        eq_sel = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            if (len_eff == LEN_W'(l))
            begin
                eq_sel = eq[l-1];
            end
        end
    end

    assign count       = {1'b0, seen} + (POS_W+1)'(1);
    assign match.hit   = (len_eff != '0) && (count >= (POS_W+1)'(len_eff)) && eq_sel;
    assign match.start = POS_W'(count - (POS_W+1)'(len_eff) + (POS_W+1)'(1));

endmodule

[design/frame_header_search_core.sv]
// Frame header search core: first-match search of a 1..8 byte header in a byte stream.
// Depends on fhs_pkg and fhs_match.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   source   | src_valid, src_stall | source_byte, last_byte
//   result   | res_valid, res_stall | found, match_position, overflowed
//   config   | cfg_write            | cfg_index, cfg_data
//
// One source byte per cycle while src_stall is low; the window compare sits between the input register
// and the state/result registers. A final byte passes from the input register into the result
// register, and waits in the input register while the result before it is still held.
// Reset clears the handshake state and the buffer state, sets the pattern length to one and clears the pattern bytes.
// src_stall rises only when a final byte waits behind an unaccepted result.
module frame_header_search_core #(
    parameter int PATTERN_MAX = 8,
    parameter int SOURCE_MAX  = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  logic [fhs_pkg::BYTE_W-1:0]    source_byte,
    input  logic                          last_byte,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          found,
    output logic [fhs_pkg::POS_W-1:0]     match_position,
    output logic                          overflowed,
    input  logic                          cfg_write,
    input  logic [fhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fhs_pkg::PAT_W-1:0]     cfg_data
);
    import fhs_pkg::*;

    localparam int CNT_W = $clog2(SOURCE_MAX + 1);

    logic [LEN_W-1:0]  pattern_length_reg;
    logic [PAT_W-1:0]  pattern_bytes_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    logic [CNT_W-1:0]  seen_reg;
    logic [CNT_W-1:0]  seen_next;
    logic              latched_reg;
    logic              latched_next;
    logic [POS_W-1:0]  first_reg;
    logic [POS_W-1:0]  first_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic              res_valid_reg;
    logic              found_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              ovf_out_reg;

    logic [PATTERN_MAX*8-1:0] hist;
    logic                     s1_go;
    logic                     examine;
    logic                     src_take;
    match_t                   match;

    assign s1_go     = s1_valid_reg && (!s1_last_reg || !res_valid_reg || !res_stall);
    assign src_stall = s1_valid_reg && !s1_go;
    assign src_take  = src_valid && !src_stall;
    assign examine   = s1_go && (seen_reg < CNT_W'(SOURCE_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LEN_W'(1);
            pattern_bytes_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                default:            pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            s1_byte_reg <= source_byte;
            s1_last_reg <= last_byte;
        end
    end

    generate
        if (PATTERN_MAX > 1)
        begin : g_window
            logic [BYTE_W-1:0] window_reg [PATTERN_MAX-1];

            always_ff @(posedge clk)
            begin
                if (examine)
                begin
                    window_reg[0] <= s1_byte_reg;
                    for (int k = 1; k < PATTERN_MAX - 1; k++)
                    begin
                        window_reg[k] <= window_reg[k-1];
                    end
                end
            end

            always_comb
            begin
                hist[BYTE_W-1:0] = s1_byte_reg;
                for (int d = 1; d < PATTERN_MAX; d++)
                begin
                    hist[8*d +: 8] = window_reg[d-1];
                end
            end
        end
        else
        begin : g_no_window
            assign hist = s1_byte_reg;
        end
    endgenerate

    fhs_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .hist           (hist),
        .seen           (POS_W'(seen_reg)),
        .pattern_length (pattern_length_reg),
        .pattern_bytes  (pattern_bytes_reg),
        .match          (match)
    );

    always_comb
    begin
        seen_next    = seen_reg;
        latched_next = latched_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        if (examine)
        begin
            seen_next = seen_reg + CNT_W'(1);
            if (!latched_reg && match.hit)
            begin
                latched_next = 1'b1;
                first_next   = match.start;
            end
        end
        else if (s1_go)
        begin
            ovf_next = 1'b1;
        end
    end

    // Advance the buffer state as each byte goes through; clear it once the final byte has gone through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            latched_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                seen_reg    <= '0;
                latched_reg <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                seen_reg    <= seen_next;
                latched_reg <= latched_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            found_reg   <= latched_next;
            pos_reg     <= latched_next ? first_next : '0;
            ovf_out_reg <= ovf_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;
    assign overflowed     = ovf_out_reg;

endmodule

[design/fhs_port_check.sv]
// Port-level checks for frame_header_search_core, attached by the bind below.
// Depends on fhs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fhs_port_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          src_valid,
    input logic                          src_stall,
    input logic [fhs_pkg::BYTE_W-1:0]    source_byte,
    input logic                          last_byte,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic                          found,
    input logic [fhs_pkg::POS_W-1:0]     match_position,
    input logic                          overflowed,
    input logic                          cfg_write,
    input logic [fhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [fhs_pkg::PAT_W-1:0]     cfg_data
);
    import fhs_pkg::*;

    `FHS_ASSERT_SAME(a_miss_pos_zero, clk, rst_n, res_valid && !found, match_position == '0, "no match but non-zero position")
    `FHS_ASSERT_SAME(a_hit_pos_nonzero, clk, rst_n, res_valid && found, match_position != '0, "match reported at position zero")
    `FHS_ASSERT_SAME(a_stall_cause, clk, rst_n, src_stall, res_valid && res_stall, "source held without a blocked result")
    `FHS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(found) && $stable(match_position) && $stable(overflowed), "stalled result changed")

endmodule

bind frame_header_search_core fhs_port_check u_port_check (.*);
